@@ rtl/lew_pkg.sv @@
// ============================================================================
// Line editor package
// Shared constants, codes and the command and status bundles that join the
// line editor controller and datapath.
// ============================================================================
package lew_pkg;

    // Sizes.
    localparam int LINE_MAX_DEF = 40;
    localparam int LEN_W        = 6;
    localparam int DATA_W       = 8;
    localparam int CFG_IDX_W    = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ERASE_CODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KILL_CODE  = 1'b1;

    localparam logic [DATA_W-1:0] ERASE_CODE_RST = 8'd127;
    localparam logic [DATA_W-1:0] KILL_CODE_RST  = 8'd21;

    // Result actions.
    localparam logic [1:0] ACT_ECHO  = 2'd0;
    localparam logic [1:0] ACT_ERASE = 2'd1;
    localparam logic [1:0] ACT_BELL  = 2'd2;
    localparam logic [1:0] ACT_END   = 2'd3;

    // Character codes.
    localparam logic [DATA_W-1:0] CH_EOF      = 8'h04;
    localparam logic [DATA_W-1:0] CH_NL       = 8'h0A;
    localparam logic [DATA_W-1:0] CH_WERASE   = 8'h17;
    localparam logic [DATA_W-1:0] CH_ESC      = 8'h1B;
    localparam logic [DATA_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [DATA_W-1:0] CH_PRINT_HI = 8'h7E;
    localparam logic [DATA_W-1:0] CH_CSI      = 8'h5B;
    localparam logic [DATA_W-1:0] CH_SS3      = 8'h4F;
    localparam logic [DATA_W-1:0] CH_FINAL_LO = 8'h40;
    localparam logic [DATA_W-1:0] CH_FINAL_HI = 8'h7E;

    // Escape filter phases.
    localparam logic [1:0] ESC_NORMAL = 2'd0;
    localparam logic [1:0] ESC_AFTER  = 2'd1;
    localparam logic [1:0] ESC_CSI    = 2'd2;
    localparam logic [1:0] ESC_SS3    = 2'd3;

    // Line length updates.
    localparam logic [2:0] LEN_HOLD = 3'd0;
    localparam logic [2:0] LEN_DEC  = 3'd1;
    localparam logic [2:0] LEN_ZERO = 3'd2;
    localparam logic [2:0] LEN_INC  = 3'd3;
    localparam logic [2:0] LEN_POS  = 3'd4;
    localparam logic [2:0] LEN_ONE  = 3'd5;
    localparam logic [2:0] LEN_WORD = 3'd6;

    // Line store writes.
    localparam logic [2:0] WR_NONE   = 3'd0;
    localparam logic [2:0] WR_APPEND = 3'd1;
    localparam logic [2:0] WR_FIRST  = 3'd2;
    localparam logic [2:0] WR_COPY   = 3'd3;
    localparam logic [2:0] WR_TAIL   = 3'd4;

    // Line store reads.
    localparam logic [1:0] RD_NONE = 2'd0;
    localparam logic [1:0] RD_SCAN = 2'd1;
    localparam logic [1:0] RD_COPY = 2'd2;

    // Scan pointer updates.
    localparam logic [1:0] POS_HOLD = 2'd0;
    localparam logic [1:0] POS_LOAD = 2'd1;
    localparam logic [1:0] POS_DEC  = 2'd2;

    // Copy index updates.
    localparam logic [1:0] IDX_HOLD  = 2'd0;
    localparam logic [1:0] IDX_CLEAR = 2'd1;
    localparam logic [1:0] IDX_INC   = 2'd2;

    // Result kinds.
    localparam logic [3:0] EM_END        = 4'd0;
    localparam logic [3:0] EM_BELL       = 4'd1;
    localparam logic [3:0] EM_ECHO_BYTE  = 4'd2;
    localparam logic [3:0] EM_ECHO_NL    = 4'd3;
    localparam logic [3:0] EM_ECHO_RAM   = 4'd4;
    localparam logic [3:0] EM_ERASE_ONE  = 4'd5;
    localparam logic [3:0] EM_ERASE_LEN  = 4'd6;
    localparam logic [3:0] EM_ERASE_TAIL = 4'd7;
    localparam logic [3:0] EM_ERASE_WORD = 4'd8;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       byte_load;
        logic       esc_step;
        logic       esc_set;
        logic       fin_set;
        logic [2:0] len_op;
        logic [2:0] wr_op;
        logic [1:0] rd_op;
        logic [1:0] pos_op;
        logic       start_load;
        logic [1:0] idx_op;
        logic       emit;
        logic [3:0] emit_op;
        logic       emit_last;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fin;
        logic esc_busy;
        logic is_eof;
        logic is_erase;
        logic is_kill;
        logic is_werase;
        logic is_esc;
        logic is_print;
        logic is_space;
        logic len_zero;
        logic len_full;
        logic pos_zero;
        logic rd_space;
        logic start_edge;
        logic tail_nonzero;
        logic copy_last;
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/lew_ram.sv @@
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data that holds
// while no read is requested.
// ============================================================================
module lew_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lew_dp.sv @@
// ============================================================================
// Line editor datapath
// Holds the line store, line length, escape phase, finished flag, the
// configuration registers, the scan and copy pointers and the result register.
// ============================================================================
module lew_dp #(
    parameter int LINE_MAX = lew_pkg::LINE_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [lew_pkg::DATA_W-1:0]     i_in_byte,
    input  logic                           i_cfg_we,
    input  logic [lew_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lew_pkg::DATA_W-1:0]     i_cfg_data,
    input  lew_pkg::t_dp_cmd               i_cmd,
    output lew_pkg::t_dp_stat              o_stat,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_action,
    output logic [lew_pkg::DATA_W-1:0]     o_echo_char,
    output logic [lew_pkg::LEN_W-1:0]      o_erase_count,
    output logic                           o_last
);

    import lew_pkg::*;

    localparam int AW = $clog2(LINE_MAX);

    // State registers.
    logic [DATA_W-1:0] r_erase_code;
    logic [DATA_W-1:0] r_kill_code;
    logic [DATA_W-1:0] r_byte;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  n_len;
    logic [1:0]        r_esc;
    logic [1:0]        n_esc;
    logic              r_fin;
    logic [LEN_W-1:0]  r_pos;
    logic [LEN_W-1:0]  r_start;
    logic [LEN_W-1:0]  r_idx;

    // Result register.
    logic              r_out_valid;
    logic [1:0]        r_action;
    logic [DATA_W-1:0] r_echo;
    logic [LEN_W-1:0]  r_count;
    logic              r_last;
    logic [1:0]        n_action;
    logic [DATA_W-1:0] n_echo;
    logic [LEN_W-1:0]  n_count;

    // Line store access.
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic              w_re;
    logic [AW-1:0]     w_raddr;
    logic [DATA_W-1:0] w_rdata;

    logic [LEN_W-1:0]  w_wlen;
    logic [LEN_W-1:0]  w_pos_m1;
    logic [LEN_W-1:0]  w_copy_src;
    logic              w_out_free;

    assign w_wlen     = r_len - r_start;
    assign w_pos_m1   = r_pos - LEN_W'(1);
    assign w_copy_src = r_start + r_idx;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_erase_code <= ERASE_CODE_RST;
            r_kill_code  <= KILL_CODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ERASE_CODE: r_erase_code <= i_cfg_data;
                REG_KILL_CODE:  r_kill_code  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Latched input word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_load) begin
            r_byte <= i_in_byte;
        end
    end

    // Escape filter: next phase after a filtered byte.
    always_comb begin
        n_esc = r_esc;
        if (i_cmd.esc_set) begin
            n_esc = ESC_AFTER;
        end else if (i_cmd.esc_step) begin
            case (r_esc)
                ESC_AFTER: begin
                    if (r_byte == CH_CSI) begin
                        n_esc = ESC_CSI;
                    end else if (r_byte == CH_SS3) begin
                        n_esc = ESC_SS3;
                    end else begin
                        n_esc = ESC_NORMAL;
                    end
                end
                ESC_CSI: begin
                    if (r_byte inside {[CH_FINAL_LO:CH_FINAL_HI]}) begin
                        n_esc = ESC_NORMAL;
                    end
                end
                default: n_esc = ESC_NORMAL;
            endcase
        end
    end

    // Line length update.
    always_comb begin
        case (i_cmd.len_op)
            LEN_HOLD: n_len = r_len;
            LEN_DEC:  n_len = r_len - LEN_W'(1);
            LEN_ZERO: n_len = '0;
            LEN_INC:  n_len = r_len + LEN_W'(1);
            LEN_POS:  n_len = r_pos;
            LEN_ONE:  n_len = LEN_W'(1);
            LEN_WORD: n_len = w_wlen + LEN_W'(1);
            default:  n_len = r_len;
        endcase
    end

    // Control state of the line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_esc <= ESC_NORMAL;
            r_fin <= 1'b0;
        end else begin
            r_len <= n_len;
            r_esc <= n_esc;
            if (i_cmd.fin_set) begin
                r_fin <= 1'b1;
            end
        end
    end

    // Scan and copy pointers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.pos_op)
            POS_LOAD: r_pos <= r_len;
            POS_DEC:  r_pos <= w_pos_m1;
            default:  ;
        endcase
        if (i_cmd.start_load) begin
            r_start <= r_pos;
        end
        case (i_cmd.idx_op)
            IDX_CLEAR: r_idx <= '0;
            IDX_INC:   r_idx <= r_idx + LEN_W'(1);
            default:   ;
        endcase
    end

    // Line store write and read selection.
    always_comb begin
        w_we    = 1'b1;
        w_waddr = r_len[AW-1:0];
        w_wdata = r_byte;
        case (i_cmd.wr_op)
            WR_APPEND: w_waddr = r_len[AW-1:0];
            WR_FIRST:  w_waddr = '0;
            WR_COPY: begin
                w_waddr = r_idx[AW-1:0];
                w_wdata = w_rdata;
            end
            WR_TAIL:   w_waddr = w_wlen[AW-1:0];
            default:   w_we = 1'b0;
        endcase
        w_re    = 1'b1;
        case (i_cmd.rd_op)
            RD_SCAN: w_raddr = w_pos_m1[AW-1:0];
            RD_COPY: w_raddr = w_copy_src[AW-1:0];
            default: begin
                w_re    = 1'b0;
                w_raddr = w_pos_m1[AW-1:0];
            end
        endcase
    end

    lew_ram #(
        .WIDTH (DATA_W),
        .DEPTH (LINE_MAX)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Fields of the next result word.
    always_comb begin
        n_action = ACT_ECHO;
        n_echo   = '0;
        n_count  = '0;
        case (i_cmd.emit_op)
            EM_END:        n_action = ACT_END;
            EM_BELL:       n_action = ACT_BELL;
            EM_ECHO_BYTE:  n_echo = r_byte;
            EM_ECHO_NL:    n_echo = CH_NL;
            EM_ECHO_RAM:   n_echo = w_rdata;
            EM_ERASE_ONE: begin
                n_action = ACT_ERASE;
                n_count  = LEN_W'(1);
            end
            EM_ERASE_LEN: begin
                n_action = ACT_ERASE;
                n_count  = r_len;
            end
            EM_ERASE_TAIL: begin
                n_action = ACT_ERASE;
                n_count  = r_len - r_pos;
            end
            EM_ERASE_WORD: begin
                n_action = ACT_ERASE;
                n_count  = w_wlen;
            end
            default:       n_action = ACT_BELL;
        endcase
    end

    // Result register: a new word loads only when the old one is gone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_action <= n_action;
            r_echo   <= n_echo;
            r_count  <= n_count;
            r_last   <= i_cmd.emit_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_action      = r_action;
    assign o_echo_char   = r_echo;
    assign o_erase_count = r_count;
    assign o_last        = r_last;

    // Status toward the controller.
    always_comb begin
        o_stat.fin          = r_fin;
        o_stat.esc_busy     = (r_esc != ESC_NORMAL);
        o_stat.is_eof       = (r_byte == CH_EOF);
        o_stat.is_erase     = (r_byte == r_erase_code);
        o_stat.is_kill      = (r_byte == r_kill_code);
        o_stat.is_werase    = (r_byte == CH_WERASE);
        o_stat.is_esc       = (r_byte == CH_ESC);
        o_stat.is_print     = (r_byte inside {[CH_SPACE:CH_PRINT_HI]});
        o_stat.is_space     = (r_byte == CH_SPACE);
        o_stat.len_zero     = (r_len == '0);
        o_stat.len_full     = (r_len == LEN_W'(LINE_MAX));
        o_stat.pos_zero     = (r_pos == '0);
        o_stat.rd_space     = (w_rdata == CH_SPACE);
        o_stat.start_edge   = (r_start == '0) || (r_start == r_len);
        o_stat.tail_nonzero = (r_len != r_pos);
        o_stat.copy_last    = ((r_idx + LEN_W'(1)) == w_wlen);
        o_stat.out_free     = w_out_free;
    end

`ifndef SYNTHESIS
    // The line never grows past its limit.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(LINE_MAX))
        else $error("line length exceeds limit");

    // The controller only loads a result when the result register is free.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> w_out_free)
        else $error("result overwritten while stalled");

    // Once input has ended it stays ended.
    a_fin_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> r_fin)
        else $error("finished flag cleared");

    // An erase result always removes at least one character.
    a_erase_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_action == ACT_ERASE) |-> (r_count != '0))
        else $error("erase of zero characters");
`endif

endmodule

@@ rtl/lew_ctrl.sv @@
// ============================================================================
// Line editor controller
// Decodes each word and steps the word-erase scan, the wrap scan and the
// word copy, one line store read at a time.
// ============================================================================
module lew_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lew_pkg::t_dp_stat  i_stat,
    output lew_pkg::t_dp_cmd   o_cmd
);

    import lew_pkg::*;

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_DECODE    = 5'd1;
    localparam logic [4:0] S_W_RD0     = 5'd2;
    localparam logic [4:0] S_W_CK0     = 5'd3;
    localparam logic [4:0] S_W_RD1     = 5'd4;
    localparam logic [4:0] S_W_CK1     = 5'd5;
    localparam logic [4:0] S_W_RD2     = 5'd6;
    localparam logic [4:0] S_W_CK2     = 5'd7;
    localparam logic [4:0] S_W_END     = 5'd8;
    localparam logic [4:0] S_WR_RD     = 5'd9;
    localparam logic [4:0] S_WR_CK     = 5'd10;
    localparam logic [4:0] S_WR_SEL    = 5'd11;
    localparam logic [4:0] S_WR_NL     = 5'd12;
    localparam logic [4:0] S_WR_SINGLE = 5'd13;
    localparam logic [4:0] S_WR_ERASE  = 5'd14;
    localparam logic [4:0] S_WR_NL2    = 5'd15;
    localparam logic [4:0] S_CP_RD     = 5'd16;
    localparam logic [4:0] S_CP_EM     = 5'd17;
    localparam logic [4:0] S_WR_FINAL  = 5'd18;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.byte_load = 1'b1;
                    n_state         = S_DECODE;
                end
            end

            // Checks in priority order; single results wait for a free slot.
            S_DECODE: begin
                if (i_stat.fin) begin
                    n_state = S_IDLE;
                end else if (i_stat.esc_busy) begin
                    o_cmd.esc_step = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_stat.is_eof) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        o_cmd.emit_op   = i_stat.len_zero ? EM_END : EM_BELL;
                        o_cmd.fin_set   = i_stat.len_zero;
                        n_state         = S_IDLE;
                    end
                end else if (i_stat.is_erase) begin
                    if (i_stat.len_zero) begin
                        n_state = S_IDLE;
                    end else if (i_stat.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        o_cmd.emit_op   = EM_ERASE_ONE;
                        o_cmd.len_op    = LEN_DEC;
                        n_state         = S_IDLE;
                    end
                end else if (i_stat.is_kill) begin
                    if (i_stat.len_zero) begin
                        n_state = S_IDLE;
                    end else if (i_stat.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        o_cmd.emit_op   = EM_ERASE_LEN;
                        o_cmd.len_op    = LEN_ZERO;
                        n_state         = S_IDLE;
                    end
                end else if (i_stat.is_werase) begin
                    o_cmd.pos_op = POS_LOAD;
                    n_state      = S_W_RD0;
                end else if (i_stat.is_esc) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        o_cmd.emit_op   = EM_BELL;
                        o_cmd.esc_set   = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else if (i_stat.is_print && !i_stat.len_full) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        o_cmd.emit_op   = EM_ECHO_BYTE;
                        o_cmd.wr_op     = WR_APPEND;
                        o_cmd.len_op    = LEN_INC;
                        n_state         = S_IDLE;
                    end
                end else if (i_stat.is_print && !i_stat.is_space) begin
                    o_cmd.pos_op = POS_LOAD;
                    n_state      = S_WR_RD;
                end else begin
                    if (i_stat.out_free) begin
                        o_cmd.emit      = 1'b1;
                        o_cmd.emit_last = 1'b1;
                        o_cmd.emit_op   = EM_BELL;
                        n_state         = S_IDLE;
                    end
                end
            end

            // Word erase, phase one: skip trailing spaces.
            S_W_RD0: begin
                if (i_stat.pos_zero) begin
                    n_state = S_W_END;
                end else begin
                    o_cmd.rd_op = RD_SCAN;
                    n_state     = S_W_CK0;
                end
            end
            S_W_CK0: begin
                o_cmd.pos_op = POS_DEC;
                n_state      = i_stat.rd_space ? S_W_RD0 : S_W_RD1;
            end

            // Phase two: remove the word.
            S_W_RD1: begin
                if (i_stat.pos_zero) begin
                    n_state = S_W_END;
                end else begin
                    o_cmd.rd_op = RD_SCAN;
                    n_state     = S_W_CK1;
                end
            end
            S_W_CK1: begin
                o_cmd.pos_op = POS_DEC;
                n_state      = i_stat.rd_space ? S_W_RD2 : S_W_RD1;
            end

            // Phase three: remove the spaces before the word.
            S_W_RD2: begin
                if (i_stat.pos_zero) begin
                    n_state = S_W_END;
                end else begin
                    o_cmd.rd_op = RD_SCAN;
                    n_state     = S_W_CK2;
                end
            end
            S_W_CK2: begin
                if (i_stat.rd_space) begin
                    o_cmd.pos_op = POS_DEC;
                    n_state      = S_W_RD2;
                end else begin
                    n_state = S_W_END;
                end
            end

            S_W_END: begin
                if (!i_stat.tail_nonzero) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.emit_op   = EM_ERASE_TAIL;
                    o_cmd.len_op    = LEN_POS;
                    n_state         = S_IDLE;
                end
            end

            // Wrap: find the last space on the full line.
            S_WR_RD: begin
                if (i_stat.pos_zero) begin
                    o_cmd.start_load = 1'b1;
                    n_state          = S_WR_SEL;
                end else begin
                    o_cmd.rd_op = RD_SCAN;
                    n_state     = S_WR_CK;
                end
            end
            S_WR_CK: begin
                if (i_stat.rd_space) begin
                    o_cmd.start_load = 1'b1;
                    n_state          = S_WR_SEL;
                end else begin
                    o_cmd.pos_op = POS_DEC;
                    n_state      = S_WR_RD;
                end
            end
            S_WR_SEL: begin
                n_state = i_stat.start_edge ? S_WR_NL : S_WR_ERASE;
            end

            // No word to carry: new line holding only the character.
            S_WR_NL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.emit_op = EM_ECHO_NL;
                    n_state       = S_WR_SINGLE;
                end
            end
            S_WR_SINGLE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.emit_op   = EM_ECHO_BYTE;
                    o_cmd.wr_op     = WR_FIRST;
                    o_cmd.len_op    = LEN_ONE;
                    n_state         = S_IDLE;
                end
            end

            // Carry the last word onto a new line.
            S_WR_ERASE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.emit_op = EM_ERASE_WORD;
                    n_state       = S_WR_NL2;
                end
            end
            S_WR_NL2: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.emit_op = EM_ECHO_NL;
                    o_cmd.idx_op  = IDX_CLEAR;
                    n_state       = S_CP_RD;
                end
            end
            S_CP_RD: begin
                o_cmd.rd_op = RD_COPY;
                n_state     = S_CP_EM;
            end
            S_CP_EM: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.emit_op = EM_ECHO_RAM;
                    o_cmd.wr_op   = WR_COPY;
                    o_cmd.idx_op  = IDX_INC;
                    n_state       = i_stat.copy_last ? S_WR_FINAL : S_CP_RD;
                end
            end
            S_WR_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.emit_op   = EM_ECHO_BYTE;
                    o_cmd.wr_op     = WR_TAIL;
                    o_cmd.len_op    = LEN_WORD;
                    n_state         = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ rtl/line_editor_word_wrap.sv @@
// ============================================================================
// Line editor with word wrap
// Canonical terminal line editor: takes keyboard bytes and answers with echo,
// erase, bell and end-of-input results, wrapping the last word of a full line.
// ============================================================================
//
//  Channel   Direction  Handshake                     Payload
//  -------   ---------  ----------------------------  -------------------------
//  input     in         i_in_valid / o_in_stall       i_in_byte
//  output    out        o_out_valid / i_out_stall     o_action, o_echo_char,
//                                                     o_erase_count, o_last
//  config    in         i_cfg_we                      i_cfg_index, i_cfg_data
//
// A word is taken only while the controller is idle, one at a time. A word
// erase and a wrap are paced by the single read port of the line RAM, which is
// read once per scanned or copied character.
// Each result waits in the output register while i_out_stall is high.
// Reset is synchronous and clears the line, escape phase and finished flag.
// The line RAM needs no clearing: only entries below the length are read.
//
module line_editor_word_wrap #(
    parameter int LINE_MAX = lew_pkg::LINE_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [lew_pkg::DATA_W-1:0]    i_in_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_action,
    output logic [lew_pkg::DATA_W-1:0]    o_echo_char,
    output logic [lew_pkg::LEN_W-1:0]     o_erase_count,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [lew_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lew_pkg::DATA_W-1:0]    i_cfg_data
);

    import lew_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencing of each word.
    lew_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Line state, line store and result register.
    lew_dp #(
        .LINE_MAX (LINE_MAX)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_byte     (i_in_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_action      (o_action),
        .o_echo_char   (o_echo_char),
        .o_erase_count (o_erase_count),
        .o_last        (o_last)
    );

endmodule
